>>> sv/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY_POP = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL_PUSH = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic [INDEX_W-1:0]       index;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top;
        logic                     empty_res;
        logic [COUNT_W-1:0]       count;
        logic [STATUS_W-1:0]      status;
    } out_word_t;

    typedef struct packed {
        logic      fire;
        out_word_t word;
    } result_t;

endpackage

>>> sv/max_heap_priority_queue_core.sv
// Binary max-heap priority queue. Each input word is a push, a pop of the
// maximum or a removal at a heap position; each gives exactly one output word
// with the new maximum (largest positive value when empty), an empty flag, the
// entry count and a status. The heap lives in one synchronous memory with one
// write and two read ports. A moving entry is carried in a register and walked
// one level at a time, by a read state and then a compare-and-write state; an
// item that fails writes no entry and goes straight to its result. One item is
// in work at a time; the output register frees the input side while a result
// waits to be taken.
module max_heap_priority_queue_core #(
    parameter int CAPACITY    = mhpq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mhpq_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output mhpq_pkg::out_word_t out_word
);

    localparam int AW = $clog2(CAPACITY);

    logic                   we;
    logic [AW-1:0]          wa;
    logic [VALUE_WIDTH-1:0] wd;
    logic [AW-1:0]          ra_a;
    logic [AW-1:0]          ra_b;
    logic [VALUE_WIDTH-1:0] rd_a;
    logic [VALUE_WIDTH-1:0] rd_b;
    logic                   out_free;
    mhpq_pkg::result_t      result;
    logic                   out_valid_reg;
    mhpq_pkg::out_word_t    out_word_reg;

    assign out_free = !out_valid_reg || out_ready;

    mhpq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .wa   (wa),
        .wd   (wd),
        .ra_a (ra_a),
        .ra_b (ra_b),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    mhpq_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && in_ready),
        .item     (in_word),
        .ready    (in_ready),
        .out_free (out_free),
        .result   (result),
        .we       (we),
        .wa       (wa),
        .wd       (wd),
        .ra_a     (ra_a),
        .ra_b     (ra_b),
        .rd_a     (rd_a),
        .rd_b     (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.fire)
        begin
            out_word_reg <= result.word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> sv/mhpq_store.sv
module mhpq_store #(
    parameter int DEPTH = mhpq_pkg::CAPACITY_DEF,
    parameter int WIDTH = mhpq_pkg::VALUE_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wa,
    input  logic [WIDTH-1:0] wd,
    input  logic [AW-1:0]    ra_a,
    input  logic [AW-1:0]    ra_b,
    output logic [WIDTH-1:0] rd_a,
    output logic [WIDTH-1:0] rd_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a <= mem[ra_a];
        rd_b <= mem[ra_b];
    end

endmodule

>>> sv/mhpq_ctrl.sv
module mhpq_ctrl #(
    parameter int CAPACITY    = mhpq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(CAPACITY)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mhpq_pkg::in_word_t     item,
    output logic                   ready,
    input  logic                   out_free,
    output mhpq_pkg::result_t      result,
    output logic                   we,
    output logic [AW-1:0]          wa,
    output logic [VALUE_WIDTH-1:0] wd,
    output logic [AW-1:0]          ra_a,
    output logic [AW-1:0]          ra_b,
    input  logic [VALUE_WIDTH-1:0] rd_a,
    input  logic [VALUE_WIDTH-1:0] rd_b
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LW  = AW + 2;
    localparam int IXW = (CW > mhpq_pkg::INDEX_W) ? CW : mhpq_pkg::INDEX_W;
    localparam int VW  = VALUE_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LAST  = 3'd1;
    localparam logic [2:0] S_UP    = 3'd2;
    localparam logic [2:0] S_UPCMP = 3'd3;
    localparam logic [2:0] S_DN    = 3'd4;
    localparam logic [2:0] S_DNCMP = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic signed [VW-1:0] MAX_POS = {1'b0, {(VW-1){1'b1}}};

    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic signed [VW-1:0]           cur_reg, cur_next;
    logic [mhpq_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                           down_reg, down_next;
    logic                           moved_reg, moved_next;
    logic signed [VW-1:0]           top_reg;

    logic signed [63:0]   value_ext;
    logic signed [VW-1:0] value_in;
    logic [AW-1:0]        parent;
    logic [LW-1:0]        left;
    logic [LW-1:0]        right;
    logic signed [VW-1:0] best_val;
    logic [LW-1:0]        best_idx;
    logic                 best_moved;
    logic signed [VW-1:0] top_val;
    logic signed [63:0]   top_ext;
    logic                 fire;

    assign value_ext = 64'(item.value);
    assign value_in  = value_ext[VW-1:0];
    assign parent    = AW'((pos_reg - 1'b1) >> 1);
    assign left      = LW'({pos_reg, 1'b1});
    assign right     = left + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        status_next = status_reg;
        down_next   = down_reg;
        moved_next  = moved_reg;
        we          = 1'b0;
        wa          = pos_reg;
        wd          = cur_reg;
        ra_a        = AW'(cnt_reg - 1'b1);
        ra_b        = '0;
        best_val    = cur_reg;
        best_idx    = LW'(pos_reg);
        best_moved  = 1'b0;
        fire        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = mhpq_pkg::STAT_OK;
                    moved_next  = 1'b0;
                    down_next   = 1'b0;
                    unique case (item.kind)
                        mhpq_pkg::KIND_PUSH:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                status_next = mhpq_pkg::STAT_FULL_PUSH;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                cur_next   = value_in;
                                pos_next   = AW'(cnt_reg);
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = S_UP;
                            end
                        end
                        mhpq_pkg::KIND_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = mhpq_pkg::STAT_EMPTY_POP;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg - 1'b1;
                                pos_next   = '0;
                                down_next  = 1'b1;
                                state_next = (cnt_reg == CW'(1)) ? S_FIN : S_LAST;
                            end
                        end
                        mhpq_pkg::KIND_REMOVE:
                        begin
                            if (IXW'(item.index) >= IXW'(cnt_reg))
                            begin
                                status_next = mhpq_pkg::STAT_BAD_INDEX;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg - 1'b1;
                                pos_next   = AW'(item.index);
                                down_next  = 1'b1;
                                state_next = (IXW'(item.index) == IXW'(cnt_reg - 1'b1))
                                             ? S_FIN : S_LAST;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_LAST:
            begin
                cur_next   = $signed(rd_a);
                state_next = S_UP;
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    if (down_reg)
                    begin
                        state_next = S_DN;
                    end
                    else
                    begin
                        we         = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    ra_a       = parent;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if ($signed(rd_a) < cur_reg)
                begin
                    we         = 1'b1;
                    wd         = rd_a;
                    pos_next   = parent;
                    moved_next = 1'b1;
                    state_next = S_UP;
                end
                else if (down_reg && !moved_reg)
                begin
                    state_next = S_DN;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN:
            begin
                if (left >= LW'(cnt_reg))
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ra_a       = left[AW-1:0];
                    ra_b       = right[AW-1:0];
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP:
            begin
                if (cur_reg < $signed(rd_a))
                begin
                    best_val   = $signed(rd_a);
                    best_idx   = left;
                    best_moved = 1'b1;
                end
                if ((right < LW'(cnt_reg)) && (best_val < $signed(rd_b)))
                begin
                    best_val   = $signed(rd_b);
                    best_idx   = right;
                    best_moved = 1'b1;
                end
                we = 1'b1;
                if (best_moved)
                begin
                    wd         = best_val;
                    pos_next   = best_idx[AW-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                fire = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            status_reg <= mhpq_pkg::STAT_OK;
            down_reg   <= 1'b0;
            moved_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            down_reg   <= down_next;
            moved_reg  <= moved_next;
        end
    end

    // root shadow, follows every write to position zero
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        if (we && (wa == '0))
        begin
            top_reg <= $signed(wd);
        end
    end

    assign top_val = (cnt_reg == '0) ? MAX_POS : top_reg;
    assign top_ext = 64'(top_val);
    assign ready   = (state_reg == S_IDLE);

    assign result.fire           = fire;
    assign result.word.top       = top_ext[mhpq_pkg::DATA_W-1:0];
    assign result.word.empty_res = (cnt_reg == '0);
    assign result.word.count     = mhpq_pkg::COUNT_W'(cnt_reg);
    assign result.word.status    = status_reg;

endmodule

>>> sv/mhpq_checker.sv
module mhpq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input mhpq_pkg::out_word_t out_word
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.count != '0) |-> !out_word.empty_res)
        else $error("empty flag set with entries held");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status == mhpq_pkg::STAT_EMPTY_POP) |-> out_word.empty_res)
        else $error("empty pop reported on a filled heap");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status == mhpq_pkg::STAT_FULL_PUSH) |-> !out_word.empty_res)
        else $error("full push reported on an empty heap");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
